@@ hdl/cpu_register_alu_execute_core_assert.svh @@
// assertion macros for the execute core
`ifndef CPU_REGISTER_ALU_EXECUTE_CORE_ASSERT_SVH
`define CPU_REGISTER_ALU_EXECUTE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define CRAE_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("execute core check failed");

`define CRAE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("execute core check failed");

`else

`define CRAE_ASSERT_SAME(lbl, clk, rstn, ante, cons)

`define CRAE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ hdl/crae_pkg.sv @@
package crae_pkg;

  typedef enum logic [3:0] {
    CmdAluReg = 4'd0,
    CmdAluImm = 4'd1,
    CmdInc8   = 4'd2,
    CmdDec8   = 4'd3,
    CmdInc16  = 4'd4,
    CmdDec16  = 4'd5,
    CmdMovReg = 4'd6,
    CmdMovImm = 4'd7,
    CmdCpl    = 4'd8,
    CmdCcf    = 4'd9,
    CmdScf    = 4'd10,
    CmdBit    = 4'd11,
    CmdRes    = 4'd12,
    CmdSet    = 4'd13
  } crae_cmd_e;

  typedef enum logic [2:0] {
    AluAdd = 3'd0,
    AluAdc = 3'd1,
    AluSub = 3'd2,
    AluSbc = 3'd3,
    AluOr  = 3'd4,
    AluAnd = 3'd5,
    AluXor = 3'd6,
    AluCp  = 3'd7
  } crae_alu_e;

  localparam logic [2:0] CodeMem = 3'd6;
  localparam logic [2:0] CodeA   = 3'd7;

  localparam logic [1:0] PairBc = 2'd0;
  localparam logic [1:0] PairDe = 2'd1;
  localparam logic [1:0] PairHl = 2'd2;
  localparam logic [1:0] PairSp = 2'd3;

  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  localparam int unsigned NumGen = 6;

  typedef struct packed {
    logic [3:0] command;
    logic [2:0] alu_select;
    logic [2:0] source_code;
    logic [2:0] target_code;
    logic [1:0] pair_code;
    logic [2:0] bit_index;
    logic [7:0] immediate;
    logic [7:0] mem_byte;
  } crae_req_t;

  typedef struct packed {
    logic [7:0]  acc_value;
    logic [3:0]  flag_bits;
    logic [15:0] bc_value;
    logic [15:0] de_value;
    logic [15:0] hl_value;
    logic [15:0] sp_value;
    logic        mem_write;
    logic [15:0] mem_address;
    logic [7:0]  mem_write_data;
  } crae_rsp_t;

  // architectural state, general registers in the order b c d e h l
  typedef struct packed {
    logic [7:0]              acc;
    logic [3:0]              flags;
    logic [NumGen-1:0][7:0]  gen;
    logic [15:0]             sp;
  } crae_state_t;

endpackage

@@ hdl/crae_regfile.sv @@
module crae_regfile (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  crae_pkg::crae_state_t state_d_i,
  output crae_pkg::crae_state_t state_q_o
);
  import crae_pkg::*;

  crae_state_t state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (load_i) begin
      state_q <= state_d_i;
    end
  end

  assign state_q_o = state_q;

endmodule

@@ hdl/crae_exec.sv @@
module crae_exec (
  input  crae_pkg::crae_req_t   req_i,
  input  crae_pkg::crae_state_t state_i,
  output crae_pkg::crae_state_t state_o,
  output crae_pkg::crae_rsp_t   rsp_o
);
  import crae_pkg::*;

  function automatic logic [7:0] rd8(input crae_state_t st, input logic [2:0] code,
                                     input logic [7:0] membyte);
    logic [7:0] v;
    case (code)
      CodeA:   v = st.acc;
      CodeMem: v = membyte;
      default: v = st.gen[code];
    endcase
    return v;
  endfunction

  crae_state_t nxt;
  logic        wr_en;
  logic [7:0]  wr_val;
  logic        mw;
  logic [7:0]  mwd;
  logic [7:0]  src_val;
  logic [7:0]  dst_val;
  logic [7:0]  alu_b;
  logic [7:0]  mask;
  logic        cin;
  logic [8:0]  add_full;
  logic [4:0]  add_half;
  logic [8:0]  sub_full;
  logic [4:0]  sub_half;
  logic [7:0]  alu_r;
  logic [3:0]  alu_f;
  logic [15:0] pair_val;
  logic [15:0] pair_new;
  logic [7:0]  inc_v;
  logic [7:0]  dec_v;

  assign src_val = rd8(state_i, req_i.source_code, req_i.mem_byte);
  assign dst_val = rd8(state_i, req_i.target_code, req_i.mem_byte);
  assign mask    = 8'd1 << req_i.bit_index;
  assign inc_v   = dst_val + 8'd1;
  assign dec_v   = dst_val - 8'd1;

  // alu datapath
  always_comb begin
    alu_b = (req_i.command == CmdAluImm) ? req_i.immediate : src_val;
    cin   = 1'b0;
    if (req_i.alu_select == AluAdc || req_i.alu_select == AluSbc) begin
      cin = state_i.flags[FlagC];
    end
    add_full = {1'b0, state_i.acc} + {1'b0, alu_b} + {8'd0, cin};
    add_half = {1'b0, state_i.acc[3:0]} + {1'b0, alu_b[3:0]} + {4'd0, cin};
    sub_full = {1'b0, state_i.acc} - {1'b0, alu_b} - {8'd0, cin};
    sub_half = {1'b0, state_i.acc[3:0]} - {1'b0, alu_b[3:0]} - {4'd0, cin};
    alu_f    = '0;
    case (req_i.alu_select)
      AluAdd, AluAdc: begin
        alu_r        = add_full[7:0];
        alu_f[FlagH] = add_half[4];
        alu_f[FlagC] = add_full[8];
      end
      AluSub, AluSbc, AluCp: begin
        alu_r        = sub_full[7:0];
        alu_f[FlagN] = 1'b1;
        alu_f[FlagH] = sub_half[4];
        alu_f[FlagC] = sub_full[8];
      end
      AluOr:   alu_r = state_i.acc | alu_b;
      AluAnd: begin
        alu_r        = state_i.acc & alu_b;
        alu_f[FlagH] = 1'b1;
      end
      default: alu_r = state_i.acc ^ alu_b;
    endcase
    alu_f[FlagZ] = (alu_r == 8'd0);
  end

  // 16-bit pair counter
  always_comb begin
    case (req_i.pair_code)
      PairBc:  pair_val = {state_i.gen[0], state_i.gen[1]};
      PairDe:  pair_val = {state_i.gen[2], state_i.gen[3]};
      PairHl:  pair_val = {state_i.gen[4], state_i.gen[5]};
      default: pair_val = state_i.sp;
    endcase
    pair_new = (req_i.command == CmdInc16) ? pair_val + 16'd1 : pair_val - 16'd1;
  end

  always_comb begin
    nxt    = state_i;
    wr_en  = 1'b0;
    wr_val = '0;
    case (req_i.command)
      CmdAluReg, CmdAluImm: begin
        nxt.flags = alu_f;
        if (req_i.alu_select != AluCp) begin
          nxt.acc = alu_r;
        end
      end
      CmdInc8: begin
        wr_en            = 1'b1;
        wr_val           = inc_v;
        nxt.flags[FlagZ] = (inc_v == 8'd0);
        nxt.flags[FlagN] = 1'b0;
        nxt.flags[FlagH] = (dst_val[3:0] == 4'hF);
      end
      CmdDec8: begin
        wr_en            = 1'b1;
        wr_val           = dec_v;
        nxt.flags[FlagZ] = (dec_v == 8'd0);
        nxt.flags[FlagN] = 1'b1;
        nxt.flags[FlagH] = (dst_val[3:0] == 4'h0);
      end
      CmdInc16, CmdDec16: begin
        case (req_i.pair_code)
          PairBc:  {nxt.gen[0], nxt.gen[1]} = pair_new;
          PairDe:  {nxt.gen[2], nxt.gen[3]} = pair_new;
          PairHl:  {nxt.gen[4], nxt.gen[5]} = pair_new;
          default: nxt.sp = pair_new;
        endcase
      end
      CmdMovReg: begin
        wr_en  = 1'b1;
        wr_val = src_val;
      end
      CmdMovImm: begin
        wr_en  = 1'b1;
        wr_val = req_i.immediate;
      end
      CmdCpl: begin
        nxt.acc          = ~state_i.acc;
        nxt.flags[FlagN] = 1'b1;
        nxt.flags[FlagH] = 1'b1;
      end
      CmdCcf: begin
        nxt.flags[FlagN] = 1'b0;
        nxt.flags[FlagH] = 1'b0;
        nxt.flags[FlagC] = ~state_i.flags[FlagC];
      end
      CmdScf: begin
        nxt.flags[FlagN] = 1'b0;
        nxt.flags[FlagH] = 1'b0;
        nxt.flags[FlagC] = 1'b1;
      end
      CmdBit: begin
        nxt.flags[FlagZ] = ((dst_val & mask) == 8'd0);
        nxt.flags[FlagN] = 1'b0;
        nxt.flags[FlagH] = 1'b1;
      end
      CmdRes: begin
        wr_en  = 1'b1;
        wr_val = dst_val & ~mask;
      end
      CmdSet: begin
        wr_en  = 1'b1;
        wr_val = dst_val | mask;
      end
      default: ;
    endcase

    // 8-bit destination write
    mw  = 1'b0;
    mwd = '0;
    if (wr_en) begin
      case (req_i.target_code)
        CodeA: nxt.acc = wr_val;
        CodeMem: begin
          mw  = 1'b1;
          mwd = wr_val;
        end
        default: nxt.gen[req_i.target_code] = wr_val;
      endcase
    end
  end

  assign state_o = nxt;

  always_comb begin
    rsp_o.acc_value      = nxt.acc;
    rsp_o.flag_bits      = nxt.flags;
    rsp_o.bc_value       = {nxt.gen[0], nxt.gen[1]};
    rsp_o.de_value       = {nxt.gen[2], nxt.gen[3]};
    rsp_o.hl_value       = {nxt.gen[4], nxt.gen[5]};
    rsp_o.sp_value       = nxt.sp;
    rsp_o.mem_write      = mw;
    rsp_o.mem_address    = {state_i.gen[4], state_i.gen[5]};
    rsp_o.mem_write_data = mwd;
  end

endmodule

@@ hdl/cpu_register_alu_execute_core.sv @@
// Execute stage for 8-bit data instructions with its own register file (A, flags ZNHC,
// B C D E H L, SP). A request is captured in an input register and executed in a
// single pass of logic against the register file when it moves into the result
// register, so one request is retired per cycle while the result register is free or
// being drained, and a new request is taken in every cycle under the same condition.
// Register code 6 reads mem_byte from the request and reports a write to memory at HL
// in the result, with the HL value from before the instruction as mem_address. The
// register file and the valid flags are zero after reset.
`include "cpu_register_alu_execute_core_assert.svh"

module cpu_register_alu_execute_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  crae_pkg::crae_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output crae_pkg::crae_rsp_t out_rsp_o
);
  import crae_pkg::*;

  logic        in_valid_q;
  crae_req_t   req_q;
  logic        out_valid_q;
  crae_rsp_t   rsp_q;
  logic        fire;
  crae_state_t state_q;
  crae_state_t state_d;
  crae_rsp_t   rsp_d;

  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

  crae_exec u_exec (
    .req_i   (req_q),
    .state_i (state_q),
    .state_o (state_d),
    .rsp_o   (rsp_d)
  );

  crae_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (fire),
    .state_d_i (state_d),
    .state_q_o (state_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  `CRAE_ASSERT_NEXT(a_fire_gives_result, clk_i, rst_ni, fire, out_valid_o)
  `CRAE_ASSERT_NEXT(a_state_only_on_fire, clk_i, rst_ni, !fire, $stable(state_q))
  `CRAE_ASSERT_SAME(a_no_write_no_data, clk_i, rst_ni, out_valid_o && !out_rsp_o.mem_write, out_rsp_o.mem_write_data == 8'd0)
  `CRAE_ASSERT_SAME(a_stall_holds_input, clk_i, rst_ni, !in_ready_o, in_valid_q && out_valid_q)

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import crae_pkg::*;

  localparam logic [3:0] CmdSpareLo = 4'd14;
  localparam logic [3:0] CmdSpareHi = 4'd15;

  localparam logic [2:0] CodeB = 3'd0;
  localparam logic [2:0] CodeC = 3'd1;
  localparam logic [2:0] CodeE = 3'd3;
  localparam logic [2:0] CodeH = 3'd4;
  localparam logic [2:0] CodeL = 3'd5;

  localparam int unsigned RandomReqs   = 1900;
  localparam int unsigned DrainAt      = 900;
  localparam int unsigned LongStallAt  = 500;
  localparam int unsigned LongStallLen = 120;
  localparam int unsigned TailCycles   = 10;
  localparam int unsigned CycleLimit   = 400000;

  typedef struct {
    crae_req_t req;
    bit        typed;
    crae_rsp_t rsp;
  } dir_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  crae_req_t in_req_i    = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  crae_rsp_t out_rsp_o;

  logic [7:0]  arch_acc;
  logic [3:0]  arch_flags;
  logic [7:0]  arch_gen [NumGen];
  logic [15:0] arch_sp;
  logic        arch_mw;
  logic [7:0]  arch_mwd;

  crae_rsp_t   retired_q [$];
  dir_row_t    dir_rows [$];
  int unsigned tx_count = 0;
  int unsigned rx_count = 0;
  int unsigned errors   = 0;

  cpu_register_alu_execute_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [7:0] read_operand(logic [2:0] code, logic [7:0] mb);
    if (code == CodeA) return arch_acc;
    if (code == CodeMem) return mb;
    return arch_gen[code];
  endfunction

  task automatic write_operand(logic [2:0] code, logic [7:0] v);
    if (code == CodeA) arch_acc = v;
    else if (code == CodeMem) begin
      arch_mw  = 1'b1;
      arch_mwd = v;
    end else arch_gen[code] = v;
  endtask

  function automatic logic [15:0] pair_value(logic [1:0] p);
    return {arch_gen[{p, 1'b0}], arch_gen[{p, 1'b1}]};
  endfunction

  task automatic alu_op(logic [2:0] sel, logic [7:0] b);
    logic [8:0] res;
    logic [4:0] half;
    logic       cin;
    logic [3:0] f;
    res = '0;
    half = '0;
    cin = 1'b0;
    f = '0;
    case (sel)
      AluAdd, AluAdc: begin
        cin = (sel == AluAdc) ? arch_flags[FlagC] : 1'b0;
        res = {1'b0, arch_acc} + {1'b0, b} + 9'(cin);
        half = {1'b0, arch_acc[3:0]} + {1'b0, b[3:0]} + 5'(cin);
        f[FlagH] = half[4];
        f[FlagC] = res[8];
      end
      AluSub, AluSbc, AluCp: begin
        cin = (sel == AluSbc) ? arch_flags[FlagC] : 1'b0;
        res = {1'b0, arch_acc} - {1'b0, b} - 9'(cin);
        half = {1'b0, arch_acc[3:0]} - {1'b0, b[3:0]} - 5'(cin);
        f[FlagH] = half[4];
        f[FlagC] = res[8];
        f[FlagN] = 1'b1;
      end
      AluOr: res = {1'b0, arch_acc | b};
      AluAnd: begin
        res = {1'b0, arch_acc & b};
        f[FlagH] = 1'b1;
      end
      default: res = {1'b0, arch_acc ^ b};
    endcase
    f[FlagZ] = (res[7:0] == 8'h00);
    arch_flags = f;
    if (sel != AluCp) arch_acc = res[7:0];
  endtask

  task automatic exec_instr(input crae_req_t r, output crae_rsp_t o);
    logic [7:0]  v;
    logic [7:0]  m;
    logic [15:0] w;
    logic [15:0] hl_old;
    hl_old = pair_value(PairHl);
    arch_mw = 1'b0;
    arch_mwd = '0;
    m = 8'd1 << r.bit_index;
    case (r.command)
      CmdAluReg: alu_op(r.alu_select, read_operand(r.source_code, r.mem_byte));
      CmdAluImm: alu_op(r.alu_select, r.immediate);
      CmdInc8: begin
        v = read_operand(r.target_code, r.mem_byte);
        write_operand(r.target_code, v + 8'd1);
        arch_flags[FlagZ] = (v == 8'hFF);
        arch_flags[FlagN] = 1'b0;
        arch_flags[FlagH] = (v[3:0] == 4'hF);
      end
      CmdDec8: begin
        v = read_operand(r.target_code, r.mem_byte);
        write_operand(r.target_code, v - 8'd1);
        arch_flags[FlagZ] = (v == 8'h01);
        arch_flags[FlagN] = 1'b1;
        arch_flags[FlagH] = (v[3:0] == 4'h0);
      end
      CmdInc16, CmdDec16: begin
        w = (r.pair_code == PairSp) ? arch_sp : pair_value(r.pair_code);
        w = (r.command == CmdInc16) ? w + 16'd1 : w - 16'd1;
        if (r.pair_code == PairSp) arch_sp = w;
        else begin
          arch_gen[{r.pair_code, 1'b0}] = w[15:8];
          arch_gen[{r.pair_code, 1'b1}] = w[7:0];
        end
      end
      CmdMovReg: write_operand(r.target_code, read_operand(r.source_code, r.mem_byte));
      CmdMovImm: write_operand(r.target_code, r.immediate);
      CmdCpl: begin
        arch_acc = ~arch_acc;
        arch_flags[FlagN] = 1'b1;
        arch_flags[FlagH] = 1'b1;
      end
      CmdCcf, CmdScf: begin
        arch_flags[FlagN] = 1'b0;
        arch_flags[FlagH] = 1'b0;
        arch_flags[FlagC] = (r.command == CmdScf) ? 1'b1 : ~arch_flags[FlagC];
      end
      CmdBit: begin
        v = read_operand(r.target_code, r.mem_byte);
        arch_flags[FlagZ] = ((v & m) == 8'h00);
        arch_flags[FlagN] = 1'b0;
        arch_flags[FlagH] = 1'b1;
      end
      CmdRes: begin
        v = read_operand(r.target_code, r.mem_byte);
        write_operand(r.target_code, v & ~m);
      end
      CmdSet: begin
        v = read_operand(r.target_code, r.mem_byte);
        write_operand(r.target_code, v | m);
      end
      default: ;
    endcase
    o.acc_value      = arch_acc;
    o.flag_bits      = arch_flags;
    o.bc_value       = pair_value(PairBc);
    o.de_value       = pair_value(PairDe);
    o.hl_value       = pair_value(PairHl);
    o.sp_value       = arch_sp;
    o.mem_write      = arch_mw;
    o.mem_address    = hl_old;
    o.mem_write_data = arch_mw ? arch_mwd : 8'h00;
  endtask

  function automatic crae_req_t mk_req(logic [3:0] cmd, logic [2:0] sel, logic [2:0] src,
                                       logic [2:0] dst, logic [1:0] pair, logic [2:0] bidx,
                                       logic [7:0] imm, logic [7:0] mb);
    crae_req_t r;
    r.command     = cmd;
    r.alu_select  = sel;
    r.source_code = src;
    r.target_code = dst;
    r.pair_code   = pair;
    r.bit_index   = bidx;
    r.immediate   = imm;
    r.mem_byte    = mb;
    return r;
  endfunction

  task automatic add_row(crae_req_t r, bit typed, crae_rsp_t e);
    dir_row_t row;
    row.req = r;
    row.typed = typed;
    row.rsp = e;
    dir_rows.push_back(row);
  endtask

  function automatic logic [7:0] corner_byte();
    logic [7:0] corners [8];
    corners = '{8'h00, 8'h01, 8'h0F, 8'h10, 8'h7F, 8'h80, 8'hFE, 8'hFF};
    if ($urandom_range(0, 3) == 0) return corners[3'($urandom_range(0, 7))];
    return 8'($urandom);
  endfunction

  function automatic crae_req_t rand_req();
    crae_req_t r;
    if ($urandom_range(0, 39) == 0) r.command = $urandom_range(0, 1) ? CmdSpareHi : CmdSpareLo;
    else r.command = 4'($urandom_range(0, 13));
    r.alu_select  = 3'($urandom);
    r.source_code = 3'($urandom);
    r.target_code = 3'($urandom);
    r.pair_code   = 2'($urandom);
    r.bit_index   = 3'($urandom);
    r.immediate   = corner_byte();
    r.mem_byte    = corner_byte();
    return r;
  endfunction

  function automatic int unsigned pick_gap(bit burst);
    int unsigned roll;
    if (burst) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("result %0d: %s got %h exp %h", rx_count, what, got, want);
    errors++;
  endtask

  task automatic check_result(crae_rsp_t got);
    crae_rsp_t want;
    if (retired_q.size() == 0) begin
      report_mismatch("result with no pending request", 16'(got.acc_value), 16'd0);
      return;
    end
    want = retired_q.pop_front();
    if (got.acc_value !== want.acc_value) begin
      report_mismatch("acc", 16'(got.acc_value), 16'(want.acc_value));
    end
    if (got.flag_bits !== want.flag_bits) begin
      report_mismatch("flags", 16'(got.flag_bits), 16'(want.flag_bits));
    end
    if (got.bc_value !== want.bc_value) report_mismatch("bc", got.bc_value, want.bc_value);
    if (got.de_value !== want.de_value) report_mismatch("de", got.de_value, want.de_value);
    if (got.hl_value !== want.hl_value) report_mismatch("hl", got.hl_value, want.hl_value);
    if (got.sp_value !== want.sp_value) report_mismatch("sp", got.sp_value, want.sp_value);
    if (got.mem_write !== want.mem_write) begin
      report_mismatch("mem_write", 16'(got.mem_write), 16'(want.mem_write));
    end
    if (got.mem_address !== want.mem_address) begin
      report_mismatch("mem_address", got.mem_address, want.mem_address);
    end
    if (got.mem_write_data !== want.mem_write_data) begin
      report_mismatch("mem_write_data", 16'(got.mem_write_data), 16'(want.mem_write_data));
    end
  endtask

  task automatic send_req(input crae_req_t r, input int unsigned gap, input bit typed,
                          input crae_rsp_t typed_rsp);
    crae_rsp_t pred;
    bit        took;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    // handshake inputs only move at the rising edge, so the falling edge sees the settled value
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    exec_instr(r, pred);
    retired_q.push_back(typed ? typed_rsp : pred);
    tx_count++;
  endtask

  initial begin : stimulus
    crae_rsp_t e;
    crae_rsp_t none;
    int unsigned n_dir;
    arch_acc = '0;
    arch_flags = '0;
    foreach (arch_gen[i]) arch_gen[i] = '0;
    arch_sp = '0;
    none = '0;

    // reset state is all zero, spare commands leave it alone
    add_row(mk_req(CmdSpareHi, AluSbc, CodeA, CodeMem, PairSp, 3'd7, 8'hFF, 8'hA5), 1'b1, none);
    e = '0;
    e.acc_value = 8'hFF;
    add_row(mk_req(CmdMovImm, AluAdd, CodeB, CodeA, PairBc, 3'd0, 8'hFF, 8'h00), 1'b1, e);
    e = '0;
    e.flag_bits = 4'((1 << FlagZ) | (1 << FlagH) | (1 << FlagC));
    add_row(mk_req(CmdAluImm, AluAdd, CodeB, CodeB, PairBc, 3'd0, 8'h01, 8'h00), 1'b1, e);
    e.mem_write = 1'b1;
    e.mem_write_data = 8'h80;
    add_row(mk_req(CmdMovImm, AluAdd, CodeB, CodeMem, PairBc, 3'd0, 8'h80, 8'h33), 1'b1, e);

    add_row(mk_req(CmdAluImm, AluAdc, CodeB, CodeB, PairBc, 3'd0, 8'h00, 8'h00), 1'b0, none);
    add_row(mk_req(CmdAluImm, AluSub, CodeB, CodeB, PairBc, 3'd0, 8'h02, 8'h00), 1'b0, none);
    add_row(mk_req(CmdAluImm, AluSbc, CodeB, CodeB, PairBc, 3'd0, 8'hFF, 8'h00), 1'b0, none);
    add_row(mk_req(CmdMovImm, AluAdd, CodeB, CodeH, PairBc, 3'd0, 8'hC0, 8'h00), 1'b0, none);
    add_row(mk_req(CmdAluReg, AluOr, CodeH, CodeB, PairBc, 3'd0, 8'h00, 8'h00), 1'b0, none);
    add_row(mk_req(CmdAluReg, AluAnd, CodeMem, CodeB, PairBc, 3'd0, 8'h00, 8'h0F), 1'b0, none);
    add_row(mk_req(CmdAluReg, AluXor, CodeA, CodeB, PairBc, 3'd0, 8'h00, 8'h00), 1'b0, none);
    add_row(mk_req(CmdAluReg, AluCp, CodeL, CodeB, PairBc, 3'd0, 8'h00, 8'h00), 1'b0, none);
    add_row(mk_req(CmdInc8, AluAdd, CodeB, CodeMem, PairBc, 3'd0, 8'h00, 8'hFF), 1'b0, none);
    add_row(mk_req(CmdDec8, AluAdd, CodeB, CodeB, PairBc, 3'd0, 8'h00, 8'h00), 1'b0, none);
    add_row(mk_req(CmdInc16, AluAdd, CodeB, CodeB, PairSp, 3'd0, 8'h00, 8'h00), 1'b0, none);
    add_row(mk_req(CmdDec16, AluAdd, CodeB, CodeB, PairDe, 3'd0, 8'h00, 8'h00), 1'b0, none);
    // memory to memory move writes mem_byte back
    add_row(mk_req(CmdMovReg, AluAdd, CodeMem, CodeMem, PairBc, 3'd0, 8'h00, 8'h5A), 1'b0, none);
    add_row(mk_req(CmdMovReg, AluAdd, CodeA, CodeE, PairBc, 3'd0, 8'h00, 8'h00), 1'b0, none);
    add_row(mk_req(CmdCpl, AluAdd, CodeB, CodeB, PairBc, 3'd0, 8'h00, 8'h00), 1'b0, none);
    add_row(mk_req(CmdCcf, AluAdd, CodeB, CodeB, PairBc, 3'd0, 8'h00, 8'h00), 1'b0, none);
    add_row(mk_req(CmdScf, AluAdd, CodeB, CodeB, PairBc, 3'd0, 8'h00, 8'h00), 1'b0, none);
    add_row(mk_req(CmdBit, AluAdd, CodeB, CodeA, PairBc, 3'd7, 8'h00, 8'h00), 1'b0, none);
    add_row(mk_req(CmdBit, AluAdd, CodeB, CodeMem, PairBc, 3'd0, 8'h00, 8'h01), 1'b0, none);
    add_row(mk_req(CmdRes, AluAdd, CodeB, CodeMem, PairBc, 3'd3, 8'h00, 8'hFF), 1'b0, none);
    add_row(mk_req(CmdSet, AluAdd, CodeB, CodeC, PairBc, 3'd7, 8'h00, 8'h00), 1'b0, none);
    add_row(mk_req(CmdSpareLo, AluXor, CodeMem, CodeMem, PairHl, 3'd5, 8'h3C, 8'hC3), 1'b0, none);
    n_dir = dir_rows.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].req, pick_gap(1'b0), dir_rows[i].typed, dir_rows[i].rsp);
    end
    for (int unsigned i = 0; i < RandomReqs; i++) begin
      if (i == DrainAt) begin
        in_valid_i <= 1'b0;
        while (retired_q.size() != 0) @(posedge clk_i);
      end
      send_req(rand_req(), pick_gap((i % 400) < 80), 1'b0, none);
    end
    in_valid_i <= 1'b0;

    while (retired_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("%0d requests sent (%0d directed), %0d results checked, %0d mismatches",
             tx_count, n_dir, rx_count, errors);
    $display("covered all alu ops, inc/dec, moves, flag ops and bit ops with random stalls");
    if (errors == 0) begin
      $display("cpu_register_alu_execute_core: match");
    end else begin
      $display("cpu_register_alu_execute_core: mismatch");
    end
    $finish;
  end

  initial begin : sink
    int unsigned stall_left;
    int unsigned g;
    bit          long_done;
    bit          hs;
    crae_rsp_t   seen;
    stall_left = 0;
    long_done = 1'b0;
    wait (rst_ni);
    forever begin
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        g = pick_gap((rx_count % 350) < 60);
        if (g == 0) out_ready_i <= 1'b1;
        else begin
          out_ready_i <= 1'b0;
          stall_left = g - 1;
        end
      end
      @(negedge clk_i);
      hs   = out_valid_o && out_ready_i;
      seen = out_rsp_o;
      @(posedge clk_i);
      if (hs) begin
        check_result(seen);
        rx_count++;
      end
      // long hold-off so the core backs up into its input
      if (!long_done && rx_count >= LongStallAt) begin
        long_done = 1'b1;
        out_ready_i <= 1'b0;
        for (int unsigned k = 0; k < LongStallLen; k++) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("cpu_register_alu_execute_core: mismatch");
    $finish;
  end

endmodule

@@ cpu_register_alu_execute_core.f @@
+incdir+hdl
hdl/crae_pkg.sv
hdl/crae_regfile.sv
hdl/crae_exec.sv
hdl/cpu_register_alu_execute_core.sv
sim/testbench.sv
